### rtl/tcw_pkg.sv
package tcw_pkg;

  // Screen geometry
  localparam int unsigned COLS   = 80;
  localparam int unsigned ROWS   = 25;
  localparam int unsigned NCELLS = ROWS * COLS;
  localparam int unsigned ADDR_W = $clog2(NCELLS);

  // Beat field widths
  localparam int unsigned FUNC_W = 2;
  localparam int unsigned CH_W   = 8;
  localparam int unsigned IDX_W  = 11;
  localparam int unsigned ROW_W  = 5;
  localparam int unsigned COL_W  = 7;
  localparam int unsigned CELL_W = 16;
  localparam int unsigned ATTR_W = 8;

  // Operation codes
  localparam logic [FUNC_W-1:0] FN_PUT   = 2'd0;
  localparam logic [FUNC_W-1:0] FN_CLEAR = 2'd1;
  localparam logic [FUNC_W-1:0] FN_READ  = 2'd2;

  // Character and attribute constants
  localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h0F;
  localparam logic [CH_W-1:0]   NEWLINE_CH = 8'h0A;
  localparam logic [CH_W-1:0]   BLANK_CH   = 8'h20;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_PUT_WR,
    ST_FILL,
    ST_RD_WAIT,
    ST_SCR_COPY,
    ST_SCR_BLANK,
    ST_RESP
  } st_e;

endpackage

### rtl/tcw_intf.sv
interface tcw_in_if;
  import tcw_pkg::*;
  logic                valid;
  logic                ready;
  logic [FUNC_W-1:0]   func;
  logic [CH_W-1:0]     ch;
  logic [IDX_W-1:0]    cell_index;

  modport source (output valid, func, ch, cell_index, input ready);
  modport sink   (input valid, func, ch, cell_index, output ready);
endinterface

interface tcw_out_if;
  import tcw_pkg::*;
  logic                valid;
  logic                ready;
  logic [ROW_W-1:0]    pos_row;
  logic [COL_W-1:0]    pos_col;
  logic [CELL_W-1:0]   cell_data;
  logic                scrolled;

  modport source (output valid, pos_row, pos_col, cell_data, scrolled, input ready);
  modport sink   (input valid, pos_row, pos_col, cell_data, scrolled, output ready);
endinterface

interface tcw_cfg_if;
  import tcw_pkg::*;
  logic                valid;
  logic                ready;
  logic [ATTR_W-1:0]   data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

### rtl/text_console_writer_unit.sv
// Text console writer: an 80x25 screen of 16-bit cells (attribute byte over
// character byte) with a cursor, held in a single-port-write RAM.
//
// Channels: in_i takes one op per beat (put char, clear, read cell); out_o
// returns exactly one beat per op with the cursor after the op, the read
// cell (zero for other ops) and a scroll flag. cfg_i writes the attribute
// byte; it is always ready and should only be written while idle.
//
// One op at a time: in_i.ready is high only while the sequencer is idle.
// The RAM walk (one cell per cycle through the single write port) serves a
// clear, which blanks every cell, and a scroll, which copies every row but the
// top one up a row and then blanks the last row; a read of an index off screen
// skips the RAM. The result sits in an output register; a stalled receiver
// holds the sequencer in its response state until that register frees.
//
// Reset: cursor homes and a clearing pass fills the screen with blanks in
// attribute 0x0F; in_i stays low-ready meanwhile.
module text_console_writer_unit (
  input  logic      clk_i,
  input  logic      rst_ni,
  tcw_in_if.sink    in_i,
  tcw_out_if.source out_o,
  tcw_cfg_if.sink   cfg_i
);
  import tcw_pkg::*;

  localparam logic [ADDR_W-1:0] COLS_A    = ADDR_W'(COLS);
  localparam logic [ADDR_W-1:0] LAST_A    = ADDR_W'(NCELLS - 1);
  localparam logic [ADDR_W-1:0] COPY_LAST = ADDR_W'(NCELLS - COLS);
  localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(ROWS - 1);
  localparam logic [COL_W-1:0]  COLS_C    = COL_W'(COLS);

  st_e               st_q, st_d;
  logic [ADDR_W-1:0] cnt_q, cnt_d;
  logic [ROW_W-1:0]  row_q, row_d;
  logic [COL_W-1:0]  col_q, col_d;
  logic              wr_pend_q, wr_pend_d;
  logic [CH_W-1:0]   ch_q, ch_d;
  logic [CELL_W-1:0] data_q, data_d;
  logic              scr_q, scr_d;
  logic [ATTR_W-1:0] attr_q;

  logic              out_valid_q, out_valid_d;
  logic              out_load;
  logic [ROW_W-1:0]  out_row_q;
  logic [COL_W-1:0]  out_col_q;
  logic [CELL_W-1:0] out_data_q;
  logic              out_scr_q;

  // RAM port signals
  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [CELL_W-1:0] wdata;
  logic              re;
  logic [ADDR_W-1:0] raddr;
  logic [CELL_W-1:0] rdata;
  logic [ADDR_W-1:0] cur_addr;

  assign cur_addr = ADDR_W'(row_q) * COLS_A + ADDR_W'(col_q);

  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (NCELLS)
  ) u_screen (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Attribute register; the user must write it only while idle, the block does not enforce it
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q <= RESET_ATTR;
    end else if (cfg_i.valid) begin
      attr_q <= cfg_i.data;
    end
  end

  // Sequencer
  always_comb begin
    st_d        = st_q;
    cnt_d       = cnt_q;
    row_d       = row_q;
    col_d       = col_q;
    wr_pend_d   = wr_pend_q;
    ch_d        = ch_q;
    data_d      = data_q;
    scr_d       = scr_q;
    we          = 1'b0;
    waddr       = cur_addr;
    wdata       = {attr_q, ch_q};
    re          = 1'b0;
    raddr       = cnt_q + COLS_A;
    in_i.ready  = 1'b0;
    out_load    = 1'b0;
    out_valid_d = out_valid_q && !out_o.ready;

    case (st_q)
      ST_INIT: begin
        // post-reset blanking pass
        we    = 1'b1;
        waddr = cnt_q;
        wdata = {RESET_ATTR, BLANK_CH};
        if (cnt_q == LAST_A) begin
          cnt_d = '0;
          st_d  = ST_IDLE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end

      ST_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          ch_d      = in_i.ch;
          data_d    = '0;
          scr_d     = 1'b0;
          wr_pend_d = 1'b0;
          cnt_d     = '0;
          case (in_i.func)
            FN_PUT: begin
              if (in_i.ch == NEWLINE_CH) begin
                col_d = '0;
                if (row_q == LAST_ROW) begin
                  scr_d = 1'b1;
                  st_d  = ST_SCR_COPY;
                end else begin
                  row_d = row_q + 1'b1;
                  st_d  = ST_RESP;
                end
              end else if (col_q == COLS_C) begin
                // deferred wrap lands now
                col_d = '0;
                if (row_q == LAST_ROW) begin
                  scr_d     = 1'b1;
                  wr_pend_d = 1'b1;
                  st_d      = ST_SCR_COPY;
                end else begin
                  row_d = row_q + 1'b1;
                  st_d  = ST_PUT_WR;
                end
              end else begin
                st_d = ST_PUT_WR;
              end
            end
            FN_CLEAR: begin
              st_d = ST_FILL;
            end
            FN_READ: begin
              if (in_i.cell_index < IDX_W'(NCELLS)) begin
                re    = 1'b1;
                raddr = ADDR_W'(in_i.cell_index);
                st_d  = ST_RD_WAIT;
              end else begin
                st_d = ST_RESP;
              end
            end
            default: begin
              st_d = ST_RESP;
            end
          endcase
        end
      end

      ST_PUT_WR: begin
        we    = 1'b1;
        col_d = col_q + 1'b1;
        st_d  = ST_RESP;
      end

      ST_FILL: begin
        we    = 1'b1;
        waddr = cnt_q;
        wdata = {attr_q, BLANK_CH};
        if (cnt_q == LAST_A) begin
          cnt_d = '0;
          row_d = '0;
          col_d = '0;
          st_d  = ST_RESP;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end

      ST_RD_WAIT: begin
        data_d = rdata;
        st_d   = ST_RESP;
      end

      ST_SCR_COPY: begin
        // read cell cnt+COLS, write the previous read one row up
        re    = (cnt_q != COPY_LAST);
        raddr = cnt_q + COLS_A;
        we    = (cnt_q != '0);
        waddr = cnt_q - 1'b1;
        wdata = rdata;
        if (cnt_q == COPY_LAST) begin
          st_d = ST_SCR_BLANK;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end

      ST_SCR_BLANK: begin
        we    = 1'b1;
        waddr = cnt_q;
        wdata = {attr_q, BLANK_CH};
        if (cnt_q == LAST_A) begin
          cnt_d = '0;
          st_d  = wr_pend_q ? ST_PUT_WR : ST_RESP;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end

      ST_RESP: begin
        if (!out_valid_q || out_o.ready) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          st_d        = ST_IDLE;
        end
      end

      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_INIT;
      cnt_q       <= '0;
      row_q       <= '0;
      col_q       <= '0;
      wr_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      cnt_q       <= cnt_d;
      row_q       <= row_d;
      col_q       <= col_d;
      wr_pend_q   <= wr_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    ch_q   <= ch_d;
    data_q <= data_d;
    scr_q  <= scr_d;
    if (out_load) begin
      out_row_q  <= row_q;
      out_col_q  <= col_q;
      out_data_q <= data_q;
      out_scr_q  <= scr_q;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.pos_row   = out_row_q;
  assign out_o.pos_col   = out_col_q;
  assign out_o.cell_data = out_data_q;
  assign out_o.scrolled  = out_scr_q;

  // Checks
  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (row_q <= LAST_ROW) && (col_q <= COLS_C))
    else $error("cursor out of range");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> (st_q != ST_IDLE))
    else $error("sequencer idle right after accept");

  a_no_idle_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_IDLE) |-> !we)
    else $error("screen write while idle");

  a_scroll_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_scr_q) |-> (out_row_q == LAST_ROW))
    else $error("scroll result not on last row");

  a_put_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_PUT_WR) |-> (col_q < COLS_C))
    else $error("put write with wrap pending");

endmodule

### rtl/tcw_ram.sv
module tcw_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 2000
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

### test/text_console_writer_unit_tb.sv
`timescale 1ns / 1ps

module text_console_writer_unit_tb;
  import tcw_pkg::*;

  // func code the block must ignore
  localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;
  // cycles with no beat on any channel before the run is called hung;
  // a clear or a scroll walks 2000 cells, the reset pass another 2000
  localparam int unsigned HANG_LIMIT = 20000;
  localparam int unsigned NDIR = 22;

  typedef struct packed {
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [CELL_W-1:0] data;
    logic              scrolled;
  } cursor_beat_t;

  // per accepted op: typed-in answer, or fall back to the screen model
  typedef struct {
    bit           known;
    cursor_beat_t val;
  } typed_ans_t;

  typedef struct {
    bit                is_cfg;  // ch carries the attribute byte
    logic [FUNC_W-1:0] fn;
    logic [CH_W-1:0]   ch;
    logic [IDX_W-1:0]  idx;
    int                rep;
    bit                known;
    cursor_beat_t      ans;
  } dir_step_t;

  logic clk_i;
  logic rst_ni;

  tcw_in_if  in_if ();
  tcw_out_if out_if ();
  tcw_cfg_if cfg_if ();

  text_console_writer_unit u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  always #2 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Screen model: own copy of the cells, cursor and attribute register
  // ---------------------------------------------------------------------------
  logic [CELL_W-1:0] screen_model [NCELLS];
  int                row_model;
  int                col_model;
  logic [ATTR_W-1:0] attr_model;

  cursor_beat_t cursor_q [$];   // expected output beats, oldest first
  typed_ans_t   typed_q [$];    // one entry per op sent, popped on accept

  int mismatches;
  int snd_idle_pct;
  int rcv_idle_pct;
  int quiet_cycles;

  function automatic void blank_screen(logic [ATTR_W-1:0] a);
    for (int i = 0; i < NCELLS; i++) screen_model[i] = {a, BLANK_CH};
    row_model = 0;
    col_model = 0;
  endfunction

  // Cursor ran off the bottom: shift rows up, blank the last one in the
  // current attribute.
  function automatic logic roll_up_check();
    if (row_model < ROWS) return 1'b0;
    for (int i = 0; i < (ROWS - 1) * COLS; i++) screen_model[i] = screen_model[i + COLS];
    for (int c = 0; c < COLS; c++) screen_model[(ROWS - 1) * COLS + c] = {attr_model, BLANK_CH};
    row_model = ROWS - 1;
    return 1'b1;
  endfunction

  function automatic cursor_beat_t step_console(logic [FUNC_W-1:0] fn, logic [CH_W-1:0] c,
                                                logic [IDX_W-1:0] ix);
    cursor_beat_t r;
    r.data     = '0;
    r.scrolled = 1'b0;
    if (fn == FN_PUT) begin
      if (c == NEWLINE_CH) begin
        col_model = 0;
        row_model++;
        r.scrolled = roll_up_check();
      end else begin
        // deferred wrap: column may sit at COLS until a non-newline character arrives
        if (col_model >= COLS) begin
          col_model = 0;
          row_model++;
          r.scrolled = roll_up_check();
        end
        screen_model[row_model * COLS + col_model] = {attr_model, c};
        col_model++;
      end
    end else if (fn == FN_CLEAR) begin
      blank_screen(attr_model);
    end else if (fn == FN_READ) begin
      if (ix < NCELLS) r.data = screen_model[ix];
    end
    r.row = ROW_W'(row_model);
    r.col = COL_W'(col_model);
    return r;
  endfunction

  task automatic report(string what, int got, int want);
    $display("%0t mismatch %s: got 0x%0h want 0x%0h", $realtime, what, got, want);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------------
  // Monitors: everything sampled at the rising edge, before any NBA lands
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && in_if.valid && in_if.ready) begin
      cursor_beat_t p;
      typed_ans_t   t;
      p = step_console(in_if.func, in_if.ch, in_if.cell_index);
      t = typed_q.pop_front();
      cursor_q.push_back(t.known ? t.val : p);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && cfg_if.valid && cfg_if.ready) attr_model = cfg_if.data;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      cursor_beat_t e;
      if (cursor_q.size() == 0) begin
        report("unexpected beat, row", out_if.pos_row, 0);
      end else begin
        e = cursor_q.pop_front();
        if (out_if.pos_row !== e.row)         report("pos_row", out_if.pos_row, e.row);
        if (out_if.pos_col !== e.col)         report("pos_col", out_if.pos_col, e.col);
        if (out_if.cell_data !== e.data)      report("cell_data", out_if.cell_data, e.data);
        if (out_if.scrolled !== e.scrolled)   report("scrolled", out_if.scrolled, e.scrolled);
      end
    end
  end

  // receiver back-pressure, percentage set per phase
  always @(posedge clk_i) out_if.ready <= ($urandom_range(99) >= rcv_idle_pct);

  // hang watchdog: any beat on any channel resets the count
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= HANG_LIMIT) begin
      $display("timeout after %0d idle cycles", quiet_cycles);
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Driver tasks; each returns right after the edge that took its beat
  // ---------------------------------------------------------------------------
  task automatic send_op(logic [FUNC_W-1:0] fn, logic [CH_W-1:0] c, logic [IDX_W-1:0] ix,
                         bit known, cursor_beat_t ans);
    typed_ans_t t;
    // sender idles cycle by cycle at the phase percentage
    while (snd_idle_pct != 0 && $urandom_range(99) < snd_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    t.known = known;
    t.val   = ans;
    typed_q.push_back(t);
    in_if.valid      <= 1'b1;
    in_if.func       <= fn;
    in_if.ch         <= c;
    in_if.cell_index <= ix;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  task automatic send_plain(logic [FUNC_W-1:0] fn, logic [CH_W-1:0] c, logic [IDX_W-1:0] ix);
    send_op(fn, c, ix, 1'b0, '0);
  endtask

  // hold off until every op has answered and the sequencer is back to idle
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (cursor_q.size() != 0 || typed_q.size() != 0 || !in_if.ready);
  endtask

  task automatic write_attr(logic [ATTR_W-1:0] a);
    wait_drained();
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= a;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
  endtask

  // Random traffic, mostly well-formed text: lines of text ended by a
  // newline (some long enough to hit the deferred wrap), read bursts on the
  // cursor row or at random, the odd clear, and some raw noise.
  task automatic run_random(int n_ops);
    int sent;
    int sel;
    int len;
    logic [IDX_W-1:0] ix;
    sent = 0;
    while (sent < n_ops) begin
      sel = $urandom_range(99);
      if (sel < 45) begin
        len = ($urandom_range(3) == 0) ? $urandom_range(75, 85) : $urandom_range(0, 12);
        for (int k = 0; k < len; k++) begin
          send_plain(FN_PUT, ($urandom_range(7) == 0) ? 8'($urandom_range(255))
                                                     : 8'($urandom_range(32, 126)),
                     IDX_W'($urandom_range(2047)));
          sent++;
        end
        send_plain(FN_PUT, NEWLINE_CH, IDX_W'($urandom_range(2047)));
        sent++;
      end else if (sel < 75) begin
        repeat ($urandom_range(1, 4)) begin
          if ($urandom_range(1) == 0) ix = IDX_W'(row_model * COLS + $urandom_range(COLS - 1));
          else ix = IDX_W'($urandom_range(2047));
          send_plain(FN_READ, 8'($urandom_range(255)), ix);
          sent++;
        end
      end else if (sel < 85) begin
        send_plain(FN_PUT, 8'($urandom_range(255)), IDX_W'($urandom_range(2047)));
        sent++;
      end else if (sel < 89) begin
        send_plain(FN_CLEAR, 8'($urandom_range(255)), IDX_W'($urandom_range(2047)));
        sent++;
      end else if (sel < 93) begin
        send_plain(FN_UNUSED, 8'($urandom_range(255)), IDX_W'($urandom_range(2047)));
        sent++;
      end else if (sel < 95) begin
        wait_drained();
      end else begin
        send_plain(FUNC_W'($urandom_range(3)), 8'($urandom_range(255)),
                   IDX_W'($urandom_range(2047)));
        sent++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Directed steps. Answers typed in where they are plain from the op;
  // zero in the known column means the screen model supplies the answer.
  // ---------------------------------------------------------------------------
  dir_step_t dir_steps [NDIR] = '{
    // fresh screen after reset: spaces in attribute 0x0F
    '{1'b0, FN_READ,   8'h00,      11'd0,    1,  1'b1, '{5'd0, 7'd0,  16'h0F20, 1'b0}},
    '{1'b0, FN_READ,   8'hFF,      11'd1999, 1,  1'b1, '{5'd0, 7'd0,  16'h0F20, 1'b0}},
    // index past the screen reads zero
    '{1'b0, FN_READ,   8'h00,      11'h7FF,  1,  1'b1, '{5'd0, 7'd0,  16'h0000, 1'b0}},
    // unused func: cursor only
    '{1'b0, FN_UNUSED, 8'hFF,      11'h7FF,  1,  1'b1, '{5'd0, 7'd0,  16'h0000, 1'b0}},
    '{1'b0, FN_PUT,    8'h41,      11'h7FF,  1,  1'b1, '{5'd0, 7'd1,  16'h0000, 1'b0}},
    '{1'b0, FN_READ,   8'h00,      11'd0,    1,  1'b1, '{5'd0, 7'd1,  16'h0F41, 1'b0}},
    '{1'b0, FN_PUT,    8'h00,      11'd0,    1,  1'b1, '{5'd0, 7'd2,  16'h0000, 1'b0}},
    '{1'b0, FN_PUT,    8'hFF,      11'd0,    1,  1'b1, '{5'd0, 7'd3,  16'h0000, 1'b0}},
    '{1'b0, FN_PUT,    NEWLINE_CH, 11'd0,    1,  1'b1, '{5'd1, 7'd0,  16'h0000, 1'b0}},
    '{1'b1, FN_PUT,    8'hFF,      11'd0,    1,  1'b0, '0},
    '{1'b0, FN_PUT,    8'h7A,      11'd0,    1,  1'b1, '{5'd1, 7'd1,  16'h0000, 1'b0}},
    '{1'b0, FN_READ,   8'h00,      11'd80,   1,  1'b1, '{5'd1, 7'd1,  16'hFF7A, 1'b0}},
    // clear blanks in the current attribute, not the reset one
    '{1'b0, FN_CLEAR,  8'h00,      11'd0,    1,  1'b1, '{5'd0, 7'd0,  16'h0000, 1'b0}},
    '{1'b0, FN_READ,   8'h00,      11'd0,    1,  1'b1, '{5'd0, 7'd0,  16'hFF20, 1'b0}},
    '{1'b1, FN_PUT,    8'h00,      11'd0,    1,  1'b0, '0},
    // full row leaves the wrap pending, next printable wraps first
    '{1'b0, FN_PUT,    8'h58,      11'd0,    80, 1'b0, '0},
    '{1'b0, FN_PUT,    8'h59,      11'd0,    1,  1'b1, '{5'd1, 7'd1,  16'h0000, 1'b0}},
    '{1'b0, FN_READ,   8'h00,      11'd80,   1,  1'b1, '{5'd1, 7'd1,  16'h0059, 1'b0}},
    // newline at a pending wrap just moves down a row
    '{1'b0, FN_PUT,    8'h58,      11'd0,    79, 1'b0, '0},
    '{1'b0, FN_PUT,    NEWLINE_CH, 11'd0,    1,  1'b1, '{5'd2, 7'd0,  16'h0000, 1'b0}},
    '{1'b0, FN_READ,   8'h00,      11'd159,  1,  1'b1, '{5'd2, 7'd0,  16'h0058, 1'b0}},
    '{1'b1, FN_PUT,    8'hFF,      11'd0,    1,  1'b0, '0}
  };

  initial begin
    clk_i            = 1'b0;
    rst_ni           = 1'b0;
    in_if.valid      = 1'b0;
    in_if.func       = FN_PUT;
    in_if.ch         = '0;
    in_if.cell_index = '0;
    out_if.ready     = 1'b0;
    cfg_if.valid     = 1'b0;
    cfg_if.data      = '0;
    mismatches       = 0;
    quiet_cycles     = 0;
    snd_idle_pct     = 13;
    rcv_idle_pct     = 47;
    attr_model       = RESET_ATTR;
    blank_screen(RESET_ATTR);

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // send_op waits out the clearing pass after reset on in ready
    foreach (dir_steps[i]) begin
      if (dir_steps[i].is_cfg) begin
        write_attr(dir_steps[i].ch);
      end else begin
        repeat (dir_steps[i].rep)
          send_op(dir_steps[i].fn, dir_steps[i].ch, dir_steps[i].idx,
                  dir_steps[i].known, dir_steps[i].ans);
      end
    end

    run_random(270);

    // sender now the slow side
    write_attr(8'($urandom_range(255)));
    snd_idle_pct = 47;
    rcv_idle_pct = 13;
    run_random(300);

    // full throughput both ways
    write_attr(8'($urandom_range(255)));
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    run_random(300);

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (cursor_q.size() != 0) report("beats never returned", 0, cursor_q.size());

    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
